// File: src/ncsel_pkg.sv
// Shared types and constants of the nearest centroid top-k selector.
package ncsel_pkg;

  localparam int unsigned MaxCentroids = 256;
  localparam int unsigned MaxDim       = 128;
  localparam int unsigned MaxProbe     = 16;
  localparam int unsigned ElemBits     = 16;
  localparam int unsigned CidBits      = 8;
  localparam int unsigned EidBits      = 7;
  localparam int unsigned SlotBits     = 4;
  localparam int unsigned DistBits     = 39;
  localparam int unsigned DiffBits     = ElemBits + 1;
  localparam int unsigned SqBits       = 2 * ElemBits;
  localparam int unsigned AccBits      = 40;
  localparam int unsigned AddrBits     = CidBits + EidBits;

  localparam logic [1:0] RegVectorLength  = 2'd0;
  localparam logic [1:0] RegCentroidCount = 2'd1;
  localparam logic [1:0] RegProbeCount    = 2'd2;

  localparam logic CmdCentroid = 1'b0;
  localparam logic CmdQuery    = 1'b1;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRun  = 5'b00010,
    StTail = 5'b00100,
    StEmit = 5'b01000,
    StDone = 5'b10000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic                start;     // clear list, zero counters
    logic                step;      // issue one element read
    logic                emit;      // present top-k results
    logic                out_take;  // current result taken
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic issue_done;   // all elements of all centroids issued
    logic pipe_empty;   // no element in flight
    logic emit_done;    // current result is the last
    logic none;         // nothing to emit
  } stat_t;

endpackage

// File: src/ncsel_ctrl.sv
// Sequencer of the nearest centroid top-k selector.
module ncsel_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  ncsel_pkg::stat_t stat_i,
  input  logic             out_ready_i,
  output ncsel_pkg::ctrl_t ctrl_o,
  output logic             busy_o,
  output logic             out_valid_o
);

  ncsel_pkg::state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    ctrl_o.start    = 1'b0;
    ctrl_o.step     = 1'b0;
    ctrl_o.emit     = 1'b0;
    ctrl_o.out_take = 1'b0;
    out_valid_o     = 1'b0;
    case (state_q)
      ncsel_pkg::StIdle: begin
        if (go_i) begin
          ctrl_o.start = 1'b1;
          state_d      = ncsel_pkg::StRun;
        end
      end
      ncsel_pkg::StRun: begin
        if (stat_i.issue_done) begin
          state_d = ncsel_pkg::StTail;
        end else begin
          ctrl_o.step = 1'b1;
        end
      end
      ncsel_pkg::StTail: begin
        if (stat_i.pipe_empty) begin
          state_d = ncsel_pkg::StEmit;
        end
      end
      ncsel_pkg::StEmit: begin
        ctrl_o.emit = 1'b1;
        if (stat_i.none) begin
          state_d = ncsel_pkg::StIdle;
        end else begin
          out_valid_o = 1'b1;
          if (out_ready_i) begin
            ctrl_o.out_take = 1'b1;
            if (stat_i.emit_done) state_d = ncsel_pkg::StDone;
          end
        end
      end
      ncsel_pkg::StDone: begin
        state_d = ncsel_pkg::StIdle;
      end
      default: state_d = ncsel_pkg::StIdle;
    endcase
  end

  assign busy_o = (state_q != ncsel_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncsel_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/ncsel_dp.sv
// Datapath: stores, distance pipeline and sorted top-k list.
module ncsel_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ncsel_pkg::ctrl_t                    ctrl_i,
  output ncsel_pkg::stat_t                    stat_o,
  input  logic                                wr_c_i,
  input  logic                                wr_q_i,
  input  logic [ncsel_pkg::CidBits-1:0]       wr_cid_i,
  input  logic [ncsel_pkg::EidBits-1:0]       wr_eid_i,
  input  logic [ncsel_pkg::ElemBits-1:0]      wr_val_i,
  input  logic [7:0]                          vlen_i,
  input  logic [8:0]                          ccnt_i,
  input  logic [4:0]                          pcnt_i,
  output logic [ncsel_pkg::CidBits-1:0]       list_id_o,
  output logic [ncsel_pkg::DistBits-1:0]      distance_o,
  output logic [ncsel_pkg::SlotBits-1:0]      rank_o,
  output logic                                last_o
);

  // clamped settings
  logic [7:0] dim;
  logic [8:0] cnt;
  logic [4:0] keep;
  assign dim  = (vlen_i > 8'(ncsel_pkg::MaxDim)) ? 8'(ncsel_pkg::MaxDim) : vlen_i;
  assign cnt  = (ccnt_i > 9'(ncsel_pkg::MaxCentroids)) ? 9'(ncsel_pkg::MaxCentroids) : ccnt_i;
  assign keep = (pcnt_i > 5'(ncsel_pkg::MaxProbe)) ? 5'(ncsel_pkg::MaxProbe) : pcnt_i;

  // memories
  logic [ncsel_pkg::ElemBits-1:0] cmem [ncsel_pkg::MaxCentroids*ncsel_pkg::MaxDim];
  logic [ncsel_pkg::ElemBits-1:0] qmem [ncsel_pkg::MaxDim];
  logic [ncsel_pkg::ElemBits-1:0] c_rd_q, q_rd_q;

  // issue counters
  logic [8:0] cid_q;
  logic [7:0] eid_q;
  logic       issue_done;
  logic       s1_v_q, s1_last_q, s2_v_q, s2_last_q, s3_v_q, s3_last_q;
  logic [ncsel_pkg::CidBits-1:0] s1_id_q, s2_id_q, s3_id_q;
  logic [ncsel_pkg::DiffBits-1:0] diff_q;
  logic [ncsel_pkg::SqBits-1:0]   sq_q;
  logic [ncsel_pkg::AccBits-1:0]  acc_q, acc_sum;
  logic                           first_q;

  assign issue_done = (cid_q >= cnt);

  always_ff @(posedge clk_i) begin
    if (wr_c_i) cmem[{wr_cid_i, wr_eid_i}] <= wr_val_i;
    if (wr_q_i) qmem[wr_eid_i] <= wr_val_i;
    c_rd_q <= cmem[{cid_q[ncsel_pkg::CidBits-1:0], eid_q[ncsel_pkg::EidBits-1:0]}];
    q_rd_q <= qmem[eid_q[ncsel_pkg::EidBits-1:0]];
    diff_q <= ncsel_pkg::DiffBits'($signed(c_rd_q)) - ncsel_pkg::DiffBits'($signed(q_rd_q));
    sq_q   <= ncsel_pkg::SqBits'($signed(diff_q) * $signed(diff_q));
    s1_id_q <= cid_q[ncsel_pkg::CidBits-1:0];
    s2_id_q <= s1_id_q;
    s3_id_q <= s2_id_q;
  end

  // element pipeline: read, subtract, square, accumulate
  logic issue_v, issue_last, issue_zero;
  assign issue_v    = ctrl_i.step && !issue_done;
  assign issue_zero = (dim == 8'd0);
  assign issue_last = issue_zero || (eid_q + 8'd1 >= dim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cid_q <= '0; eid_q <= '0;
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0;
      s1_last_q <= 1'b0; s2_last_q <= 1'b0; s3_last_q <= 1'b0;
      first_q <= 1'b1;
    end else begin
      if (ctrl_i.start) begin
        cid_q <= '0; eid_q <= '0; first_q <= 1'b1;
      end else if (issue_v) begin
        if (issue_last) begin
          eid_q <= '0; cid_q <= cid_q + 9'd1;
        end else begin
          eid_q <= eid_q + 8'd1;
        end
      end
      s1_v_q <= issue_v; s1_last_q <= issue_last;
      s2_v_q <= s1_v_q;  s2_last_q <= s1_last_q;
      s3_v_q <= s2_v_q;  s3_last_q <= s2_last_q;
      if (s3_v_q) first_q <= s3_last_q;
    end
  end

  // zero-length vectors contribute nothing
  logic [ncsel_pkg::SqBits-1:0] sq_use;
  assign sq_use  = issue_zero ? '0 : sq_q;
  assign acc_sum = (first_q ? '0 : acc_q) + ncsel_pkg::AccBits'(sq_use);

  always_ff @(posedge clk_i) begin
    if (s3_v_q) acc_q <= acc_sum;
  end

  // one distance per centroid offered to the list
  logic                          off_v_q;
  logic [ncsel_pkg::AccBits-1:0] off_d_q;
  logic [ncsel_pkg::CidBits-1:0] off_id_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) off_v_q <= 1'b0;
    else         off_v_q <= s3_v_q && s3_last_q;
  end
  always_ff @(posedge clk_i) begin
    off_d_q  <= acc_sum;
    off_id_q <= s3_id_q;
  end

  // sorted insertion list; valid by fill count
  logic [ncsel_pkg::AccBits-1:0] bd_q [ncsel_pkg::MaxProbe];
  logic [ncsel_pkg::CidBits-1:0] bi_q [ncsel_pkg::MaxProbe];
  logic [4:0]                    fill_q;
  logic [ncsel_pkg::MaxProbe-1:0] gt;  // slot holds strictly larger, or empty
  logic                           take;

  always_comb begin
    for (int i = 0; i < ncsel_pkg::MaxProbe; i++) begin
      gt[i] = (5'(i) >= fill_q) || (bd_q[i] > off_d_q);
    end
  end
  assign take = off_v_q && (keep != 5'd0) &&
                ((fill_q < keep) || gt[4'(keep - 5'd1)]);

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < ncsel_pkg::MaxProbe; i++) begin
        if (5'(i) < keep) begin
          if (gt[i]) begin
            if (i == 0 || !gt[i-1 < 0 ? 0 : i-1]) begin
              bd_q[i] <= off_d_q; bi_q[i] <= off_id_q;
            end else begin
              bd_q[i] <= bd_q[i-1 < 0 ? 0 : i-1]; bi_q[i] <= bi_q[i-1 < 0 ? 0 : i-1];
            end
          end
        end
      end
    end
  end

  // output walk
  logic [4:0] rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; rd_q <= '0;
    end else begin
      if (ctrl_i.start) begin
        fill_q <= '0; rd_q <= '0;
      end else begin
        if (take && fill_q < keep) fill_q <= fill_q + 5'd1;
        if (ctrl_i.out_take) rd_q <= rd_q + 5'd1;
      end
    end
  end

  assign list_id_o  = bi_q[rd_q[ncsel_pkg::SlotBits-1:0]];
  assign distance_o = bd_q[rd_q[ncsel_pkg::SlotBits-1:0]][ncsel_pkg::DistBits-1:0];
  assign rank_o     = rd_q[ncsel_pkg::SlotBits-1:0];
  assign last_o     = (rd_q + 5'd1 == fill_q);

  assign stat_o.issue_done = issue_done;
  assign stat_o.pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q && !off_v_q;
  assign stat_o.emit_done  = last_o;
  assign stat_o.none       = (fill_q == 5'd0) && ctrl_i.emit;

endmodule

// File: src/nearest_centroid_top_k_selector.sv
// Top level of the nearest centroid top-k selector.
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   tdata, tuser, tlast
//  m_axis   out  m_axis_tvalid/tready   tdata, tlast
//  cfg      in   cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
// Loads and non-final query items are accepted while the selector is idle.
// A final query item runs a search that reads one element per cycle, every
// element of every centroid (one read per centroid when vector_length is zero),
// through the single centroid memory read port, then drains the pipeline;
// results leave one per cycle while m_axis_tready is high, after which it returns to idle.
// Reset restores register defaults and clears the result list count.
// Input is held off while a search or its results are in progress.
module nearest_centroid_top_k_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // centroid_index[7:0], element_index[14:8], value[30:15]
  input  logic        s_axis_tuser,  // cmd
  input  logic        s_axis_tlast,  // last_of_query
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // list_id[7:0], distance[46:8], rank[50:47]
  output logic        m_axis_tlast,  // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  logic [7:0] vlen_q;
  logic [8:0] ccnt_q;
  logic [4:0] pcnt_q;
  logic       busy, acc, go;
  ncsel_pkg::ctrl_t ctrl;
  ncsel_pkg::stat_t stat;
  logic [ncsel_pkg::CidBits-1:0]  lid;
  logic [ncsel_pkg::DistBits-1:0] dist_w;
  logic [ncsel_pkg::SlotBits-1:0] rnk;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign go  = acc && (s_axis_tuser == ncsel_pkg::CmdQuery) && s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= 8'd128; ccnt_q <= 9'd256; pcnt_q <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ncsel_pkg::RegVectorLength:  vlen_q <= cfg_data_i[7:0];
        ncsel_pkg::RegCentroidCount: ccnt_q <= cfg_data_i;
        ncsel_pkg::RegProbeCount:    pcnt_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  ncsel_ctrl u_ctrl (
    .clk_i, .rst_ni, .go_i(go), .stat_i(stat), .out_ready_i(m_axis_tready),
    .ctrl_o(ctrl), .busy_o(busy), .out_valid_o(m_axis_tvalid)
  );

  ncsel_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .wr_c_i(acc && s_axis_tuser == ncsel_pkg::CmdCentroid),
    .wr_q_i(acc && s_axis_tuser == ncsel_pkg::CmdQuery),
    .wr_cid_i(s_axis_tdata[7:0]), .wr_eid_i(s_axis_tdata[14:8]),
    .wr_val_i(s_axis_tdata[30:15]),
    .vlen_i(vlen_q), .ccnt_i(ccnt_q), .pcnt_i(pcnt_q),
    .list_id_o(lid), .distance_o(dist_w), .rank_o(rnk), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, rnk, dist_w, lid};

endmodule
